// File: sv/at_line_framer_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// AT line framer assertion macros
// Shared assertion wrappers; defining ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef AT_LINE_FRAMER_CLASSIFIER_UNIT_DEFINES_SVH
`define AT_LINE_FRAMER_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ATLFC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("atlfc assertion failed");
// next-cycle implication
`define ATLFC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("atlfc assertion failed");
`else
`define ATLFC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define ATLFC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// File: sv/atlfc_pkg.sv
// ----------------------------------------------------------------------------
// AT line framer package
// Types, codes, match strings and helper functions of the line framer.
// ----------------------------------------------------------------------------
`default_nettype none

package atlfc_pkg;

    localparam int MAX_LINE = 128;
    localparam int CNT_W    = 8;
    localparam int KIND_W   = 3;
    localparam int CODE_W   = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO_END = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESP_END = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PROMPT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BINARY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd5;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd6;

    // response classes
    localparam logic [CODE_W-1:0] CODE_INFO  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OK    = 2'd1;
    localparam logic [CODE_W-1:0] CODE_ERROR = 2'd2;
    localparam logic [CODE_W-1:0] CODE_EXT   = 2'd3;

    // register indexes
    localparam logic REG_PROMPT_CHARS  = 1'b0;
    localparam logic REG_PROMPT_LENGTH = 1'b1;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_T  = 8'h54;

    localparam logic [7:0] TXT_OK  [2]  = '{8'h4F, 8'h4B};
    localparam logic [7:0] TXT_ERR [5]  = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
    localparam logic [7:0] TXT_CMS [11] = '{8'h2B, 8'h43, 8'h4D, 8'h53, 8'h20, 8'h45,
                                           8'h52, 8'h52, 8'h4F, 8'h52, 8'h3A};
    localparam logic [7:0] TXT_CME [11] = '{8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20, 8'h45,
                                           8'h52, 8'h52, 8'h4F, 8'h52, 8'h3A};

    typedef enum logic [4:0] {
        PH_AWAIT  = 5'b00001,
        PH_GOT_CR = 5'b00010,
        PH_GOT_A  = 5'b00100,
        PH_RESP   = 5'b01000,
        PH_ECHO   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic [CNT_W-1:0]  line_length;
        logic [CODE_W-1:0] result_code;
        logic              last;
    } t_result;

    // flags: bit 0 OK, bit 1 ERROR, bit 2 +CMS, bit 3 +CME
    function automatic logic [3:0] upd_codes(input logic [3:0] f,
                                             input logic [CNT_W-1:0] p,
                                             input logic [7:0] b);
        logic [3:0] r;
        r = f;
        if (p >= 8'd2 || b != TXT_OK[p[0]])
            r[0] = 1'b0;
        if (p >= 8'd5 || b != TXT_ERR[p[2:0]])
            r[1] = 1'b0;
        if (p < 8'd11 && b != TXT_CMS[p[3:0]])
            r[2] = 1'b0;
        if (p < 8'd11 && b != TXT_CME[p[3:0]])
            r[3] = 1'b0;
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] classify(input logic [3:0] f,
                                                   input logic [CNT_W-1:0] n);
        logic [CODE_W-1:0] r;
        r = CODE_INFO;
        if (f[0] && n == 8'd2)
            r = CODE_OK;
        else if (f[1] && n == 8'd5)
            r = CODE_ERROR;
        else if ((f[2] || f[3]) && n >= 8'd11)
            r = CODE_EXT;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/atlfc_if.sv
// ----------------------------------------------------------------------------
// AT line framer channels
// Valid/ready channels for received bytes and for framer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface atlfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atlfc_res_if;
    logic                            valid;
    logic                            ready;
    logic [atlfc_pkg::KIND_W-1:0]    kind;
    logic [7:0]                      data_byte;
    logic [atlfc_pkg::CNT_W-1:0]     line_length;
    logic [atlfc_pkg::CODE_W-1:0]    result_code;
    logic                            last;

    modport source (output valid, output kind, output data_byte, output line_length,
                    output result_code, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input line_length,
                    input result_code, input last, output ready);
endinterface

`default_nettype wire

// File: sv/at_line_framer_classifier_unit.sv
// ----------------------------------------------------------------------------
// AT line framer and classifier
// Frames received modem bytes into echo and response lines, passes payload
// through and classifies result codes, prompts, overflow and empty lines.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                          | handshake
//  i_rx      | in  | rx_byte                                          | valid/ready
//  o_res     | out | kind, data_byte, line_length, result_code, last  | valid/ready
//  APB       | in  | prompt_chars @0x0, prompt_length @0x4            | psel/penable
//
//  One byte per cycle while ready is high: the framer decodes a request in the
//  cycle it is accepted and writes one or two results into a four-entry queue.
//  Input ready is high while the queue has room for two results.
//  From an empty queue, the first result is visible the cycle after the byte is accepted.
//  Synchronous active-low reset clears framer state, queue and registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "at_line_framer_classifier_unit_defines.svh"

module at_line_framer_classifier_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    atlfc_rx_if.sink         i_rx,
    atlfc_res_if.source      o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [atlfc_pkg::CNT_W-1:0] MAX_CNT = atlfc_pkg::CNT_W'(atlfc_pkg::MAX_LINE);

    // configuration
    logic [31:0] r_pchars;
    logic [2:0]  r_plen;
    logic        cfg_wr;

    // framer state
    atlfc_pkg::t_phase             r_phase, n_phase;
    logic                          r_pend,  n_pend;
    logic [atlfc_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic                          r_pm,    n_pm;
    logic [3:0]                    r_flags, n_flags;

    atlfc_pkg::t_result            res [2];
    logic [1:0]                    nres;

    // result queue
    atlfc_pkg::t_result            r_fifo [4];
    logic [1:0]                    r_wptr, r_rptr;
    logic [2:0]                    r_count;
    logic                          acc, pop;
    logic [1:0]                    push;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == atlfc_pkg::REG_PROMPT_LENGTH) ? {29'b0, r_plen} : r_pchars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pchars <= '0;
            r_plen   <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == atlfc_pkg::REG_PROMPT_CHARS)
                r_pchars <= pwdata;
            else
                r_plen <= pwdata[2:0];
        end
    end

    assign acc = i_rx.valid && i_rx.ready;
    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        logic [7:0]                  b;
        logic [2:0]                  plen;
        logic [8:0]                  pos;
        logic                        done;
        logic [atlfc_pkg::CNT_W-1:0] cnt1;
        logic [3:0]                  flags1;

        b       = i_rx.rx_byte;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_pm    = r_pm;
        n_flags = r_flags;
        res[0]  = '0;
        res[1]  = '0;
        nres    = 2'd0;
        done    = 1'b0;
        cnt1    = r_cnt;
        flags1  = r_flags;
        plen    = (r_plen > 3'd4) ? 3'd4 : r_plen;
        pos     = {1'b0, r_cnt} + 9'(r_pend);

        case (r_phase)
            atlfc_pkg::PH_AWAIT: begin
                if (b == atlfc_pkg::CH_CR)
                    n_phase = atlfc_pkg::PH_GOT_CR;
                else if (b == atlfc_pkg::CH_A)
                    n_phase = atlfc_pkg::PH_GOT_A;
                else begin
                    res[0].kind = atlfc_pkg::KIND_BINARY;
                    nres        = 2'd1;
                end
            end
            atlfc_pkg::PH_GOT_CR, atlfc_pkg::PH_GOT_A: begin
                if ((r_phase == atlfc_pkg::PH_GOT_CR && b == atlfc_pkg::CH_LF) ||
                    (r_phase == atlfc_pkg::PH_GOT_A && b == atlfc_pkg::CH_T)) begin
                    n_phase = (r_phase == atlfc_pkg::PH_GOT_CR) ? atlfc_pkg::PH_RESP
                                                               : atlfc_pkg::PH_ECHO;
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    n_pm    = 1'b1;
                    n_flags = 4'hF;
                end else begin
                    res[0].kind = atlfc_pkg::KIND_BINARY;
                    nres        = 2'd1;
                    n_phase     = atlfc_pkg::PH_AWAIT;
                end
            end
            atlfc_pkg::PH_ECHO: begin
                nres = 2'd1;
                if (b == atlfc_pkg::CH_CR) begin
                    if (r_cnt == '0)
                        res[0].kind = atlfc_pkg::KIND_EMPTY;
                    else begin
                        res[0].kind        = atlfc_pkg::KIND_ECHO_END;
                        res[0].line_length = r_cnt;
                    end
                    n_phase = atlfc_pkg::PH_AWAIT;
                end else if (r_cnt >= MAX_CNT) begin
                    res[0].kind        = atlfc_pkg::KIND_OVERFLOW;
                    res[0].line_length = r_cnt;
                    n_phase            = atlfc_pkg::PH_AWAIT;
                end else begin
                    res[0].kind      = atlfc_pkg::KIND_PAYLOAD;
                    res[0].data_byte = b;
                    n_flags          = atlfc_pkg::upd_codes(r_flags, r_cnt, b);
                    n_cnt            = r_cnt + 8'd1;
                end
            end
            atlfc_pkg::PH_RESP: begin
                // prompt check looks at the first body bytes, a held CR included
                if (plen != 3'd0 && pos < 9'(plen)) begin
                    if (r_pm && b == r_pchars[{pos[1:0], 3'b000} +: 8]) begin
                        if (pos == 9'(plen) - 9'd1) begin
                            res[0].kind        = atlfc_pkg::KIND_PROMPT;
                            res[0].line_length = 8'(plen);
                            nres               = 2'd1;
                            n_phase            = atlfc_pkg::PH_AWAIT;
                            done               = 1'b1;
                        end
                    end else
                        n_pm = 1'b0;
                end
                if (!done && r_pend) begin
                    n_pend = 1'b0;
                    if (b == atlfc_pkg::CH_LF) begin
                        if (r_cnt == '0)
                            res[0].kind = atlfc_pkg::KIND_EMPTY;
                        else begin
                            res[0].kind        = atlfc_pkg::KIND_RESP_END;
                            res[0].line_length = r_cnt;
                            res[0].result_code = atlfc_pkg::classify(r_flags, r_cnt);
                        end
                        nres    = 2'd1;
                        n_phase = atlfc_pkg::PH_AWAIT;
                        done    = 1'b1;
                    end else if (r_cnt >= MAX_CNT) begin
                        res[0].kind        = atlfc_pkg::KIND_OVERFLOW;
                        res[0].line_length = r_cnt;
                        nres               = 2'd1;
                        n_phase            = atlfc_pkg::PH_AWAIT;
                        done               = 1'b1;
                    end else begin
                        // held CR was payload after all
                        res[0].kind      = atlfc_pkg::KIND_PAYLOAD;
                        res[0].data_byte = atlfc_pkg::CH_CR;
                        flags1           = atlfc_pkg::upd_codes(r_flags, r_cnt,
                                                                atlfc_pkg::CH_CR);
                        cnt1             = r_cnt + 8'd1;
                        nres             = 2'd1;
                        n_flags          = flags1;
                        n_cnt            = cnt1;
                    end
                end
                if (!done) begin
                    if (b == atlfc_pkg::CH_CR)
                        n_pend = 1'b1;
                    else if (cnt1 >= MAX_CNT) begin
                        res[nres[0]].kind        = atlfc_pkg::KIND_OVERFLOW;
                        res[nres[0]].line_length = cnt1;
                        nres                     = nres + 2'd1;
                        n_phase                  = atlfc_pkg::PH_AWAIT;
                    end else begin
                        res[nres[0]].kind      = atlfc_pkg::KIND_PAYLOAD;
                        res[nres[0]].data_byte = b;
                        nres                   = nres + 2'd1;
                        n_flags                = atlfc_pkg::upd_codes(flags1, cnt1, b);
                        n_cnt                  = cnt1 + 8'd1;
                    end
                end
            end
            default: begin
                n_phase = atlfc_pkg::PH_AWAIT;
            end
        endcase

        if (nres == 2'd1)
            res[0].last = 1'b1;
        else if (nres == 2'd2)
            res[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= atlfc_pkg::PH_AWAIT;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_pm    <= 1'b1;
            r_flags <= 4'hF;
        end else if (acc) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_pm    <= n_pm;
            r_flags <= n_flags;
        end
    end

    // result queue
    assign push        = acc ? nres : 2'd0;
    assign i_rx.ready  = (r_count <= 3'd2);
    assign o_res.valid = (r_count != 3'd0);

    assign o_res.kind        = r_fifo[r_rptr].kind;
    assign o_res.data_byte   = r_fifo[r_rptr].data_byte;
    assign o_res.line_length = r_fifo[r_rptr].line_length;
    assign o_res.result_code = r_fifo[r_rptr].result_code;
    assign o_res.last        = r_fifo[r_rptr].last;

    always_ff @(posedge i_clk) begin
        if (push != 2'd0)
            r_fifo[r_wptr] <= res[0];
        if (push == 2'd2)
            r_fifo[r_wptr + 2'd1] <= res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + push;
            r_rptr  <= r_rptr + 2'(pop);
            r_count <= r_count + 3'(push) - 3'(pop);
        end
    end

    `ATLFC_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'd4)
    `ATLFC_ASSERT_IMP(a_two_from_held_cr, i_clk, i_rst_n, acc && nres == 2'd2, r_phase == atlfc_pkg::PH_RESP && r_pend)
    `ATLFC_ASSERT_IMP(a_line_bound, i_clk, i_rst_n, 1'b1, r_cnt <= MAX_CNT)
    `ATLFC_ASSERT_NXT(a_queue_count, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) + 3'($past(push)) - 3'($past(pop)))

endmodule

`default_nettype wire

// File: dv/at_line_framer_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// AT line framer and classifier testbench
// Streams received bytes into the framer and checks every result against a
// cycle-free predictor of the framing, prompt and result-code logic. Prompt
// registers are set over APB between traffic phases; random bursts, receiver
// stalls and a long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module at_line_framer_classifier_unit_tb;

    typedef logic [7:0] t_octet;

    localparam logic [2:0] ADDR_PROMPT_CHARS  = {atlfc_pkg::REG_PROMPT_CHARS, 2'b00};
    localparam logic [2:0] ADDR_PROMPT_LENGTH = {atlfc_pkg::REG_PROMPT_LENGTH, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    atlfc_rx_if  rx_ch ();
    atlfc_res_if res_ch ();

    at_line_framer_classifier_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // code strings in flag order: OK, ERROR, +CMS, +CME
    string code_text [4] = '{"OK", "ERROR", "+CMS ERROR:", "+CME ERROR:"};

    // framer prediction state
    atlfc_pkg::t_phase  frame_phase;
    logic               held_cr;
    logic [7:0]         line_count;
    logic               prompt_alive;
    logic [3:0]         code_alive;
    logic [31:0]        cfg_prompt_chars;
    logic [2:0]         cfg_prompt_len;

    atlfc_pkg::t_result byte_results [$];
    atlfc_pkg::t_result framer_results_due [$];

    int          mismatch_count = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          stall_window = 0;
    logic [15:0] stall_bits = '1;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic string result_text(input atlfc_pkg::t_result r);
        return $sformatf("kind %0d data %02h len %0d code %0d last %0d",
                         r.kind, r.data_byte, r.line_length, r.result_code, r.last);
    endfunction

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void open_line(input atlfc_pkg::t_phase ph);
        frame_phase  = ph;
        held_cr      = 1'b0;
        line_count   = '0;
        prompt_alive = 1'b1;
        code_alive   = 4'hF;
    endfunction

    function automatic void reset_framer_model();
        cfg_prompt_chars = '0;
        cfg_prompt_len   = '0;
        open_line(atlfc_pkg::PH_AWAIT);
        framer_results_due.delete();
    endfunction

    function automatic void add_result(input logic [atlfc_pkg::KIND_W-1:0] kind,
                                       input t_octet data, input logic [7:0] len,
                                       input logic [atlfc_pkg::CODE_W-1:0] code);
        atlfc_pkg::t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.line_length = len;
        r.result_code = code;
        r.last        = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void track_codes(input t_octet b);
        int p;
        p = line_count;
        if (p >= 2 || b != code_text[0][p])
            code_alive[0] = 1'b0;
        if (p >= 5 || b != code_text[1][p])
            code_alive[1] = 1'b0;
        if (p < 11 && b != code_text[2][p])
            code_alive[2] = 1'b0;
        if (p < 11 && b != code_text[3][p])
            code_alive[3] = 1'b0;
    endfunction

    function automatic logic [atlfc_pkg::CODE_W-1:0] response_class();
        if (code_alive[0] && line_count == 8'd2)
            return atlfc_pkg::CODE_OK;
        if (code_alive[1] && line_count == 8'd5)
            return atlfc_pkg::CODE_ERROR;
        if ((code_alive[2] || code_alive[3]) && line_count >= 8'd11)
            return atlfc_pkg::CODE_EXT;
        return atlfc_pkg::CODE_INFO;
    endfunction

    // returns 0 when the line overflowed and framing restarts
    function automatic bit pass_payload(input t_octet b);
        if (line_count >= atlfc_pkg::MAX_LINE) begin
            add_result(atlfc_pkg::KIND_OVERFLOW, 8'h00, line_count, atlfc_pkg::CODE_INFO);
            frame_phase = atlfc_pkg::PH_AWAIT;
            return 1'b0;
        end
        track_codes(b);
        add_result(atlfc_pkg::KIND_PAYLOAD, b, 8'd0, atlfc_pkg::CODE_INFO);
        line_count++;
        return 1'b1;
    endfunction

    function automatic void frame_byte(input t_octet b);
        int plen;
        int pos;
        bit done;
        byte_results.delete();
        done = 1'b0;
        case (frame_phase)
            atlfc_pkg::PH_AWAIT: begin
                if (b == atlfc_pkg::CH_CR)
                    frame_phase = atlfc_pkg::PH_GOT_CR;
                else if (b == atlfc_pkg::CH_A)
                    frame_phase = atlfc_pkg::PH_GOT_A;
                else
                    add_result(atlfc_pkg::KIND_BINARY, 8'h00, 8'd0, atlfc_pkg::CODE_INFO);
            end
            atlfc_pkg::PH_GOT_CR: begin
                if (b == atlfc_pkg::CH_LF) begin
                    open_line(atlfc_pkg::PH_RESP);
                end else begin
                    add_result(atlfc_pkg::KIND_BINARY, 8'h00, 8'd0, atlfc_pkg::CODE_INFO);
                    frame_phase = atlfc_pkg::PH_AWAIT;
                end
            end
            atlfc_pkg::PH_GOT_A: begin
                if (b == atlfc_pkg::CH_T) begin
                    open_line(atlfc_pkg::PH_ECHO);
                end else begin
                    add_result(atlfc_pkg::KIND_BINARY, 8'h00, 8'd0, atlfc_pkg::CODE_INFO);
                    frame_phase = atlfc_pkg::PH_AWAIT;
                end
            end
            atlfc_pkg::PH_ECHO: begin
                if (b == atlfc_pkg::CH_CR) begin
                    if (line_count == 0)
                        add_result(atlfc_pkg::KIND_EMPTY, 8'h00, 8'd0, atlfc_pkg::CODE_INFO);
                    else
                        add_result(atlfc_pkg::KIND_ECHO_END, 8'h00, line_count,
                                   atlfc_pkg::CODE_INFO);
                    frame_phase = atlfc_pkg::PH_AWAIT;
                end else begin
                    void'(pass_payload(b));
                end
            end
            atlfc_pkg::PH_RESP: begin
                plen = (cfg_prompt_len > 3'd4) ? 4 : cfg_prompt_len;
                // a held CR occupies a prompt position
                pos = line_count + held_cr;
                if (plen != 0 && pos < plen) begin
                    if (prompt_alive && b == cfg_prompt_chars[8*pos +: 8]) begin
                        if (pos == plen - 1) begin
                            add_result(atlfc_pkg::KIND_PROMPT, 8'h00, 8'(plen),
                                       atlfc_pkg::CODE_INFO);
                            frame_phase = atlfc_pkg::PH_AWAIT;
                            done = 1'b1;
                        end
                    end else begin
                        prompt_alive = 1'b0;
                    end
                end
                if (!done && held_cr) begin
                    if (b == atlfc_pkg::CH_LF) begin
                        if (line_count == 0)
                            add_result(atlfc_pkg::KIND_EMPTY, 8'h00, 8'd0,
                                       atlfc_pkg::CODE_INFO);
                        else
                            add_result(atlfc_pkg::KIND_RESP_END, 8'h00, line_count,
                                       response_class());
                        frame_phase = atlfc_pkg::PH_AWAIT;
                        held_cr = 1'b0;
                        done = 1'b1;
                    end else begin
                        held_cr = 1'b0;
                        if (!pass_payload(atlfc_pkg::CH_CR))
                            done = 1'b1;
                    end
                end
                if (!done) begin
                    if (b == atlfc_pkg::CH_CR)
                        held_cr = 1'b1;
                    else
                        void'(pass_payload(b));
                end
            end
            default: frame_phase = atlfc_pkg::PH_AWAIT;
        endcase
        if (byte_results.size() != 0)
            byte_results[byte_results.size()-1].last = 1'b1;
        foreach (byte_results[i])
            framer_results_due.push_back(byte_results[i]);
    endfunction

    // ------------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        atlfc_pkg::t_result seen;
        atlfc_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.kind        = res_ch.kind;
            seen.data_byte   = res_ch.data_byte;
            seen.line_length = res_ch.line_length;
            seen.result_code = res_ch.result_code;
            seen.last        = res_ch.last;
            if (framer_results_due.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", result_text(seen)));
            end else begin
                want = framer_results_due.pop_front();
                if (seen !== want)
                    note_failure($sformatf("result mismatch: expected %s, got %s",
                                           result_text(want), result_text(seen)));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            if (stall_window == 0) begin
                stall_window = $urandom_range(16, 96);
                // a quarter of the windows run without stalls
                stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom) | 16'h0101);
            end
            stall_window--;
            res_ch.ready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_octet b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready)
            @(posedge i_clk);
        burst_left--;
        bytes_sent++;
        frame_byte(b);
    endtask

    task automatic send_bytes(input t_octet seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // stop the requests and let every outstanding result drain
    task automatic settle();
        int guard;
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        guard = 0;
        while (framer_results_due.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] stored;
        logic [31:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_PROMPT_CHARS)
            cfg_prompt_chars = value;
        else
            cfg_prompt_len = value[2:0];
        stored = (addr == ADDR_PROMPT_CHARS) ? cfg_prompt_chars : {29'd0, cfg_prompt_len};
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored)
            note_failure($sformatf("register %0h read back %08h, expected %08h",
                                   addr, readback, stored));
    endtask

    // ------------------------------------------------------------------------
    // line builders
    // ------------------------------------------------------------------------
    function automatic void add_text(ref t_octet q [$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic void add_crlf(ref t_octet q [$]);
        q.push_back(atlfc_pkg::CH_CR);
        q.push_back(atlfc_pkg::CH_LF);
    endfunction

    function automatic void add_filler(ref t_octet q [$], input int n, input bit with_cr);
        t_octet b;
        repeat (n) begin
            b = t_octet'($urandom_range(0, 255));
            if (with_cr && $urandom_range(0, 7) == 0)
                b = atlfc_pkg::CH_CR;
            else if (!with_cr && b == atlfc_pkg::CH_CR)
                b = 8'h20;
            q.push_back(b);
        end
    endfunction

    function automatic void add_response_body(ref t_octet q [$]);
        int k;
        int n;
        int idx;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 8))
            0: add_text(q, code_text[$urandom_range(0, 1)]);
            1: begin
                add_text(q, code_text[$urandom_range(2, 3)]);
                if ($urandom_range(0, 1) != 0)
                    q.push_back(8'h20);
                repeat ($urandom_range(0, 3))
                    q.push_back(t_octet'(8'h30 + $urandom_range(0, 9)));
            end
            2: begin
                // result code cut to a random length, possibly whole
                n = $urandom_range(0, code_text[k].len());
                for (int i = 0; i < n; i++)
                    q.push_back(code_text[k][i]);
            end
            3: begin
                add_text(q, code_text[k]);
                add_filler(q, $urandom_range(1, 3), 1'b0);
            end
            4: begin
                // one byte of the code corrupted
                idx = $urandom_range(0, code_text[k].len() - 1);
                for (int i = 0; i < code_text[k].len(); i++)
                    q.push_back((i == idx) ? t_octet'($urandom_range(0, 255)) : code_text[k][i]);
            end
            5: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    q.push_back(cfg_prompt_chars[8*i +: 8]);
                add_filler(q, $urandom_range(0, 3), 1'b1);
            end
            6, 7: add_filler(q, $urandom_range(0, 16), 1'b1);
            default: add_filler(q, $urandom_range(0, 3), 1'b1);
        endcase
    endfunction

    task automatic send_random_line();
        t_octet line [$];
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            add_filler(line, $urandom_range(1, 4), 1'b0);
            if ($urandom_range(0, 3) == 0)
                line.push_back(atlfc_pkg::CH_CR);
        end else if (sel < 34) begin
            add_text(line, "AT");
            add_filler(line, $urandom_range(0, 12), 1'b0);
            if ($urandom_range(0, 9) != 0)
                line.push_back(atlfc_pkg::CH_CR);
        end else if (sel < 97) begin
            add_crlf(line);
            add_response_body(line);
            if ($urandom_range(0, 9) != 0)
                add_crlf(line);
        end else if ($urandom_range(0, 1) != 0) begin
            // lines around the length limit
            add_text(line, "AT");
            add_filler(line, $urandom_range(atlfc_pkg::MAX_LINE - 4, atlfc_pkg::MAX_LINE + 4),
                       1'b0);
            line.push_back(atlfc_pkg::CH_CR);
        end else begin
            add_crlf(line);
            add_filler(line, $urandom_range(atlfc_pkg::MAX_LINE - 4, atlfc_pkg::MAX_LINE + 4),
                       1'b0);
            add_crlf(line);
        end
        send_bytes(line);
    endtask

    task automatic run_random_lines(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_line();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        write_register(ADDR_PROMPT_CHARS, 32'hFFFF_FFFF);
        write_register(ADDR_PROMPT_LENGTH, 32'd7);
        write_register(ADDR_PROMPT_CHARS, 32'h0000_0000);
        write_register(ADDR_PROMPT_LENGTH, 32'd0);
    endtask

    task automatic test_framing_directed();
        t_octet seq [$];
        seq.push_back(8'h00);                   // binary prefixes at both extremes
        seq.push_back(8'hFF);
        add_text(seq, "AT");                    // empty echo line
        seq.push_back(atlfc_pkg::CH_CR);
        add_crlf(seq);
        add_text(seq, "OK");
        add_crlf(seq);
        add_crlf(seq);                          // empty response line
        add_crlf(seq);
        seq.push_back(atlfc_pkg::CH_CR);        // broken prefixes
        add_text(seq, "Z");
        add_text(seq, "AZ");
        add_crlf(seq);                          // held CR released, then CR CR LF
        add_text(seq, "E");
        seq.push_back(atlfc_pkg::CH_CR);
        add_text(seq, "R");
        seq.push_back(atlfc_pkg::CH_CR);
        add_crlf(seq);
        send_bytes(seq);
        settle();
    endtask

    task automatic run_prompt_phase(input logic [31:0] chars, input logic [2:0] len,
                                    input int n_bytes);
        t_octet seq [$];
        settle();
        write_register(ADDR_PROMPT_CHARS, chars);
        write_register(ADDR_PROMPT_LENGTH, {29'd0, len});
        add_crlf(seq);
        for (int i = 0; i < ((len > 3'd4) ? 4 : len); i++)
            seq.push_back(chars[8*i +: 8]);
        send_bytes(seq);
        run_random_lines(n_bytes);
        settle();
    endtask

    task automatic test_prompt_settings();
        run_prompt_phase(32'h0000_203E, 3'd2, 180);
        run_prompt_phase(32'hFFFF_FFFF, 3'd4, 180);
        run_prompt_phase($urandom, 3'd7, 180);
        run_prompt_phase(32'h0000_000D, 3'd1, 180);
        run_prompt_phase($urandom, 3'd3, 180);
        run_prompt_phase(32'h0000_0000, 3'd4, 180);
    endtask

    // receiver holds off while long lines keep arriving, so the input stalls
    task automatic test_result_backpressure();
        t_octet seq [$];
        settle();
        write_register(ADDR_PROMPT_LENGTH, 32'd0);
        hold_request = 300;
        add_text(seq, "AT");
        add_filler(seq, atlfc_pkg::MAX_LINE, 1'b0);
        seq.push_back(atlfc_pkg::CH_CR);
        add_crlf(seq);
        add_filler(seq, atlfc_pkg::MAX_LINE + 2, 1'b0);
        add_crlf(seq);
        send_bytes(seq);
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        reset_framer_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_framing_directed();
        test_prompt_settings();
        test_result_backpressure();

        settle();
        repeat (16) @(posedge i_clk);
        if (framer_results_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", framer_results_due.size()));
        if (mismatch_count == 0)
            $display("PASS at_line_framer_classifier_unit");
        else
            $display("FAIL at_line_framer_classifier_unit");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL at_line_framer_classifier_unit");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/atlfc_pkg.sv
sv/atlfc_if.sv
sv/at_line_framer_classifier_unit.sv
dv/at_line_framer_classifier_unit_tb.sv
